// ===== sv/pbc_pkg.sv =====
package pbc_pkg;

  localparam int MAX_DIMENSION   = 4096;
  localparam int PALETTE_ENTRIES = 256;

  localparam int CFG_W     = 13;
  localparam int DIM_W     = 13;
  localparam int TOTAL_W   = $clog2(MAX_DIMENSION * MAX_DIMENSION + 1);
  localparam int COUNT_W   = 24;
  localparam int PAL_AW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int PAL_DW    = 24;
  localparam int SUM_W     = 29;

  localparam logic [1:0] FMT_YUV  = 2'd0;
  localparam logic [1:0] FMT_RGB  = 2'd1;
  localparam logic [1:0] FMT_PAL  = 2'd2;
  localparam logic [1:0] FMT_NONE = 2'd3;

  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic       OP_CONVERT   = 1'b0;
  localparam logic       OP_PAL_WRITE = 1'b1;

  // Q14 coefficients; chroma ones pre-scaled by 8 to share the Q18 sum
  localparam logic signed [SUM_W-1:0] K_Y  = SUM_W'(19076);
  localparam logic signed [SUM_W-1:0] K_RV = SUM_W'(8 * 26146);
  localparam logic signed [SUM_W-1:0] K_GU = SUM_W'(8 * 6418);
  localparam logic signed [SUM_W-1:0] K_GV = SUM_W'(8 * 13319);
  localparam logic signed [SUM_W-1:0] K_BU = SUM_W'(8 * 33047);

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = DIM_W'(1);
    end else if (32'(d) > MAX_DIMENSION) begin
      r = DIM_W'(MAX_DIMENSION);
    end else begin
      r = DIM_W'(d);
    end
    return r;
  endfunction

  function automatic logic [7:0] to_byte(input logic signed [SUM_W-1:0] s);
    logic [7:0] r;
    if (s[SUM_W-1]) begin
      r = 8'd0;
    end else if (s[SUM_W-2:26] != '0) begin
      r = 8'hFF;
    end else begin
      r = s[25:18];
    end
    return r;
  endfunction

endpackage

// ===== sv/pixel_to_bgra_converter_core.sv =====
// A pixel request is registered in stage 1 and then in the output register.
// One request per cycle unless stalled; palette read and YUV multipliers are one stage each.
// Palette writes and requests in the unused format are accepted and emit nothing.
// Reset (rst, synchronous): format YUV, frame 1x1, pixel counter zero, pipeline empty.
// Palette contents are not cleared by reset and must be written before use.
module pixel_to_bgra_converter_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [pbc_pkg::CFG_W-1:0] cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      operation,
  input  logic [7:0]                byte_a,
  input  logic [7:0]                byte_b,
  input  logic [7:0]                byte_c,
  input  logic [7:0]                entry_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                blue,
  output logic [7:0]                green,
  output logic [7:0]                red,
  output logic [7:0]                alpha,
  output logic                      frame_end
);
  import pbc_pkg::*;

  logic [1:0]         fmt;
  logic [DIM_W-1:0]   width_c, height_c;
  logic [TOTAL_W-1:0] total;
  logic [COUNT_W-1:0] count, count_next;
  logic [TOTAL_W-1:0] count_inc;
  logic               last_pix;

  logic               accept, pix_req, pal_wr, out_en;
  logic               v1;
  logic [1:0]         s1_fmt;
  logic [7:0]         s1_a, s1_b, s1_c;
  logic               s1_fe, s1_pal_ok;
  logic [PAL_DW-1:0]  pal_rd;
  logic [7:0]         csc_r, csc_g, csc_b;
  logic [7:0]         r_sel, g_sel, b_sel;

  assign accept  = in_valid && !in_stall;
  assign pix_req = accept && (operation == OP_CONVERT) && (fmt != FMT_NONE);
  assign pal_wr  = accept && (operation == OP_PAL_WRITE)
                   && (32'(entry_index) < PALETTE_ENTRIES);
  assign out_en  = !out_valid || !out_stall;
  assign in_stall = v1 && !out_en;

  // configuration; frame size product is formed at the write
  always_ff @(posedge clk) begin
    if (rst) begin
      fmt      <= FMT_YUV;
      width_c  <= DIM_W'(1);
      height_c <= DIM_W'(1);
      total    <= TOTAL_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FORMAT: fmt <= cfg_data[1:0];
        REG_WIDTH: begin
          width_c <= clamp_dim(cfg_data);
          total   <= TOTAL_W'(clamp_dim(cfg_data)) * TOTAL_W'(height_c);
        end
        REG_HEIGHT: begin
          height_c <= clamp_dim(cfg_data);
          total    <= TOTAL_W'(width_c) * TOTAL_W'(clamp_dim(cfg_data));
        end
        default: ;
      endcase
    end
  end

  assign count_inc = TOTAL_W'(count) + TOTAL_W'(1);
  assign last_pix  = count_inc >= total;

  always_comb begin
    count_next = count;
    if (cfg_write && (cfg_index == REG_FORMAT || cfg_index == REG_WIDTH
                      || cfg_index == REG_HEIGHT)) begin
      count_next = '0;
    end else if (pix_req) begin
      count_next = last_pix ? '0 : count_inc[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  pbc_palette u_palette (
    .clk     (clk),
    .wr_en   (pal_wr),
    .wr_addr (entry_index[PAL_AW-1:0]),
    .wr_data ({byte_a, byte_b, byte_c}),
    .rd_en   (pix_req),
    .rd_addr (byte_a[PAL_AW-1:0]),
    .rd_data (pal_rd)
  );

  pbc_csc u_csc (
    .clk  (clk),
    .load (pix_req),
    .y    (byte_a),
    .u    (byte_b),
    .v    (byte_c),
    .r    (csc_r),
    .g    (csc_g),
    .b    (csc_b)
  );

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (pix_req) begin
      v1 <= 1'b1;
    end else if (out_en) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_req) begin
      s1_fmt    <= fmt;
      s1_a      <= byte_a;
      s1_b      <= byte_b;
      s1_c      <= byte_c;
      s1_fe     <= last_pix;
      s1_pal_ok <= 32'(byte_a) < PALETTE_ENTRIES;
    end
  end

  always_comb begin
    case (s1_fmt)
      FMT_YUV: begin
        r_sel = csc_r;
        g_sel = csc_g;
        b_sel = csc_b;
      end
      FMT_RGB: begin
        r_sel = s1_a;
        g_sel = s1_b;
        b_sel = s1_c;
      end
      FMT_PAL: begin
        r_sel = s1_pal_ok ? pal_rd[23:16] : 8'd0;
        g_sel = s1_pal_ok ? pal_rd[15:8]  : 8'd0;
        b_sel = s1_pal_ok ? pal_rd[7:0]   : 8'd0;
      end
      default: begin
        r_sel = 8'd0;
        g_sel = 8'd0;
        b_sel = 8'd0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && v1) begin
      red       <= r_sel;
      green     <= g_sel;
      blue      <= b_sel;
      frame_end <= s1_fe;
    end
  end

  assign alpha = ALPHA_OPAQUE;

  a_count_in_frame: assert property (@(posedge clk) disable iff (rst)
    TOTAL_W'(count) < total)
    else $error("pixel counter beyond frame size");

  a_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    total != '0)
    else $error("frame size is zero");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_write && cfg_index == REG_WIDTH |=> count == '0)
    else $error("register write did not restart the frame");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v1 && out_valid)
    else $error("input stalled with room in the pipeline");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    pix_req && last_pix && !cfg_write |=> count == '0)
    else $error("counter did not wrap on last pixel");

endmodule

// ===== sv/pbc_palette.sv =====
module pbc_palette (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [pbc_pkg::PAL_AW-1:0] wr_addr,
  input  logic [pbc_pkg::PAL_DW-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [pbc_pkg::PAL_AW-1:0] rd_addr,
  output logic [pbc_pkg::PAL_DW-1:0] rd_data
);
  import pbc_pkg::*;

  logic [PAL_DW-1:0] mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/pbc_csc.sv =====
module pbc_csc (
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] y,
  input  logic [7:0] u,
  input  logic [7:0] v,
  output logic [7:0] r,
  output logic [7:0] g,
  output logic [7:0] b
);
  import pbc_pkg::*;

  logic signed [SUM_W-1:0] ly_d, cu_d, cv_d;
  logic signed [SUM_W-1:0] p_y, p_rv, p_gu, p_gv, p_bu;
  logic signed [SUM_W-1:0] s_r, s_g, s_b;

  assign ly_d = $signed(SUM_W'({y, 4'b0000})) - SUM_W'(255);
  assign cu_d = $signed(SUM_W'({u, 1'b0})) - SUM_W'(255);
  assign cv_d = $signed(SUM_W'({v, 1'b0})) - SUM_W'(255);

  always_ff @(posedge clk) begin
    if (load) begin
      p_y  <= SUM_W'(ly_d * K_Y);
      p_rv <= SUM_W'(cv_d * K_RV);
      p_gu <= SUM_W'(cu_d * K_GU);
      p_gv <= SUM_W'(cv_d * K_GV);
      p_bu <= SUM_W'(cu_d * K_BU);
    end
  end

  assign s_r = p_y + p_rv;
  assign s_g = p_y - p_gu - p_gv;
  assign s_b = p_y + p_bu;

  assign r = to_byte(s_r);
  assign g = to_byte(s_g);
  assign b = to_byte(s_b);

endmodule
